// ----- rtl/rtc_handshake_serial_slave_macros.svh -----
// assertion macros shared by the rtl files
`ifndef RTC_HANDSHAKE_SERIAL_SLAVE_MACROS_SVH
`define RTC_HANDSHAKE_SERIAL_SLAVE_MACROS_SVH

`ifndef ASSERT_OFF

// condition implies consequence in the same cycle
`define RHSS_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("rhss assertion failed");

// condition implies consequence in the next cycle
`define RHSS_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("rhss assertion failed");

`else

`define RHSS_ASSERT_NOW(label, clk, rst, cond, cons)
`define RHSS_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// ----- rtl/rhss_pkg.sv -----
// shared types and constants for the rtc handshake serial slave
`timescale 1ns / 1ps

package rhss_pkg;

  localparam logic [7:0] CMD_READ_CLOCK = 8'hFD;
  localparam int         REPLY_LEN      = 6;
  localparam logic [2:0] REPLY_LAST_IDX = 3'(REPLY_LEN);
  localparam logic [3:0] GATE_DATA_HIGH = 4'd3;
  localparam logic       KIND_LINE      = 1'b0;
  localparam logic       KIND_STATUS    = 1'b1;
  localparam logic       REG_GATE_ID    = 1'b0;

  typedef struct packed {
    logic       kind;
    logic       cpu_clock;
    logic       cpu_data;
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [4:0] now_day;
    logic [2:0] now_weekday;
    logic [3:0] now_month;
    logic [6:0] now_year;
  } item_t;

  typedef struct packed {
    logic [3:0] port_a_value;
    logic [4:0] port8_value;
    logic       device_clock;
    logic       device_data;
    logic       sending;
  } result_t;

endpackage

// ----- rtl/rtc_handshake_serial_slave.sv -----
// top level: apb register, core and output queue
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_stall  | kind, cpu_clock, cpu_data, now_* time
//  out     | out_valid/out_stall| port_a_value, port8_value, device_clock,
//          |                    | device_data, sending
//  cfg     | apb psel/penable   | gate_id at byte address 0
//
// one item per cycle while in_stall is low; a taken item's result goes to out_res,
// or to the skid while out_res stalls; a two-entry output queue (result register
// plus skid) sets the stall: in_stall rises only when both entries hold unread results
// synchronous reset clears all link state, the reply bytes and gate_id
`timescale 1ns / 1ps
`include "rtc_handshake_serial_slave_macros.svh"

module rtc_handshake_serial_slave (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic        cpu_clock,
  input  logic        cpu_data,
  input  logic [5:0]  now_second,
  input  logic [5:0]  now_minute,
  input  logic [4:0]  now_hour,
  input  logic [4:0]  now_day,
  input  logic [2:0]  now_weekday,
  input  logic [3:0]  now_month,
  input  logic [6:0]  now_year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  port_a_value,
  output logic [4:0]  port8_value,
  output logic        device_clock,
  output logic        device_data,
  output logic        sending
);

  logic [3:0]        gate_id;
  rhss_pkg::item_t   item;
  rhss_pkg::result_t core_res;
  rhss_pkg::result_t out_res;
  rhss_pkg::result_t skid_res;
  logic              skid_valid;
  logic              accept;
  logic              out_move;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_id <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == rhss_pkg::REG_GATE_ID) begin
      gate_id <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == rhss_pkg::REG_GATE_ID) ? {28'd0, gate_id} : 32'd0;

  assign item = '{kind: kind, cpu_clock: cpu_clock, cpu_data: cpu_data,
                  now_second: now_second, now_minute: now_minute, now_hour: now_hour,
                  now_day: now_day, now_weekday: now_weekday, now_month: now_month,
                  now_year: now_year};

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  // result register is free when empty or being taken
  assign out_move = !out_valid || !out_stall;

  rhss_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .gate_id (gate_id),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_move) begin
        out_valid  <= skid_valid || accept;
        skid_valid <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      out_res <= skid_valid ? skid_res : core_res;
    end else if (accept) begin
      skid_res <= core_res;
    end
  end

  assign port_a_value = out_res.port_a_value;
  assign port8_value  = out_res.port8_value;
  assign device_clock = out_res.device_clock;
  assign device_data  = out_res.device_data;
  assign sending      = out_res.sending;

  `RHSS_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `RHSS_ASSERT_NEXT(a_stalled_push_skids, clk, rst, accept && out_valid && out_stall, skid_valid)
  `RHSS_ASSERT_NEXT(a_drain_empties, clk, rst, out_valid && !out_stall && !accept && !skid_valid, !out_valid)

endmodule

// ----- rtl/rhss_core.sv -----
// link state and per-item next-state logic
`timescale 1ns / 1ps
`include "rtc_handshake_serial_slave_macros.svh"

module rhss_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  rhss_pkg::item_t  item,
  input  logic [3:0]       gate_id,
  output rhss_pkg::result_t result
);

  logic       host_clock_seen, host_clock_seen_next;
  logic       host_data_seen, host_data_seen_next;
  logic       ready_clock, ready_clock_next;
  logic       data_out, data_out_next;
  logic       send_mode, send_mode_next;
  logic [2:0] bits_in, bits_in_next;
  logic [2:0] bits_out, bits_out_next;
  logic [7:0] in_shift, in_shift_next;
  logic [7:0] out_shift, out_shift_next;
  logic [2:0] reply_index, reply_index_next;
  logic       reply_start_pending, reply_start_pending_next;
  logic [7:0] reply_bytes [rhss_pkg::REPLY_LEN];
  logic       latch;
  logic [6:0] year_fix;
  logic [3:0] wday_nib;
  logic [3:0] status_before;

  assign year_fix = (item.now_year >= 7'd100) ? item.now_year - 7'd100 : item.now_year;
  assign wday_nib = {1'b0, item.now_weekday} + 4'd15;
  assign status_before = {ready_clock, host_data_seen, host_clock_seen, 1'b0};

  always_comb begin
    host_clock_seen_next     = host_clock_seen;
    host_data_seen_next      = host_data_seen;
    ready_clock_next         = ready_clock;
    data_out_next            = data_out;
    send_mode_next           = send_mode;
    bits_in_next             = bits_in;
    bits_out_next            = bits_out;
    in_shift_next            = in_shift;
    out_shift_next           = out_shift;
    reply_index_next         = reply_index;
    reply_start_pending_next = reply_start_pending;
    latch                    = 1'b0;

    if (item.kind == rhss_pkg::KIND_STATUS) begin
      // first status read after the command starts the reply
      if (reply_start_pending && send_mode) begin
        ready_clock_next         = 1'b1;
        reply_index_next         = '0;
        reply_start_pending_next = 1'b0;
      end
    end else begin
      host_data_seen_next = item.cpu_data;
      if (item.cpu_clock != host_clock_seen) begin
        host_clock_seen_next = item.cpu_clock;
        if (!send_mode) begin
          if (item.cpu_clock) begin
            ready_clock_next = 1'b1;
          end else begin
            in_shift_next    = {in_shift[6:0], item.cpu_data};
            bits_in_next     = bits_in + 3'd1;
            ready_clock_next = 1'b0;
            if (bits_in_next == 3'd0 && in_shift_next == rhss_pkg::CMD_READ_CLOCK) begin
              latch                    = 1'b1;
              reply_index_next         = '0;
              reply_start_pending_next = 1'b1;
              bits_out_next            = '0;
              send_mode_next           = 1'b1;
            end
          end
        end else begin
          if (item.cpu_clock) begin
            // byte boundary: load the next reply byte, or zero while the start is pending or after the last byte
            if (bits_out == 3'd0) begin
              if (reply_start_pending) begin
                out_shift_next           = '0;
                reply_start_pending_next = 1'b0;
              end else if (reply_index < rhss_pkg::REPLY_LAST_IDX) begin
                out_shift_next   = reply_bytes[reply_index];
                reply_index_next = reply_index + 3'd1;
              end else begin
                out_shift_next = '0;
              end
            end
            data_out_next    = out_shift_next[7];
            ready_clock_next = 1'b0;
          end else begin
            bits_out_next  = bits_out + 3'd1;
            out_shift_next = {out_shift[6:0], 1'b0};
            if (bits_out_next == 3'd0) begin
              if (reply_index < rhss_pkg::REPLY_LAST_IDX) begin
                ready_clock_next = 1'b1;
              end else begin
                send_mode_next = 1'b0;
              end
            end else begin
              ready_clock_next = 1'b1;
            end
          end
        end
      end
    end

    if (item.kind == rhss_pkg::KIND_STATUS) begin
      result.port_a_value = status_before;
    end else begin
      result.port_a_value = {ready_clock_next, host_data_seen_next, host_clock_seen_next, 1'b0};
    end
    if (!data_out_next) begin
      result.port8_value = 5'h00;
    end else if (gate_id < rhss_pkg::GATE_DATA_HIGH) begin
      result.port8_value = 5'h10;
    end else begin
      result.port8_value = 5'h04;
    end
    result.device_clock = ready_clock_next;
    result.device_data  = data_out_next;
    result.sending      = send_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_clock_seen     <= 1'b0;
      host_data_seen      <= 1'b0;
      ready_clock         <= 1'b0;
      data_out            <= 1'b0;
      send_mode           <= 1'b0;
      bits_in             <= '0;
      bits_out            <= '0;
      in_shift            <= '0;
      out_shift           <= '0;
      reply_index         <= '0;
      reply_start_pending <= 1'b0;
      for (int i = 0; i < rhss_pkg::REPLY_LEN; i++) begin
        reply_bytes[i] <= '0;
      end
    end else if (accept) begin
      host_clock_seen     <= host_clock_seen_next;
      host_data_seen      <= host_data_seen_next;
      ready_clock         <= ready_clock_next;
      data_out            <= data_out_next;
      send_mode           <= send_mode_next;
      bits_in             <= bits_in_next;
      bits_out            <= bits_out_next;
      in_shift            <= in_shift_next;
      out_shift           <= out_shift_next;
      reply_index         <= reply_index_next;
      reply_start_pending <= reply_start_pending_next;
      if (latch) begin
        reply_bytes[0] <= {2'b00, item.now_second};
        reply_bytes[1] <= {2'b00, item.now_minute};
        reply_bytes[2] <= {3'b000, item.now_hour};
        reply_bytes[3] <= {3'b000, item.now_day};
        reply_bytes[4] <= {wday_nib, item.now_month};
        reply_bytes[5] <= {1'b0, year_fix};
      end
    end
  end

  // a pending start only exists in send mode, with the index parked at zero
  `RHSS_ASSERT_NOW(a_pending_in_send, clk, rst, reply_start_pending, send_mode)
  `RHSS_ASSERT_NOW(a_pending_idx_zero, clk, rst, reply_start_pending, reply_index == 3'd0)
  `RHSS_ASSERT_NOW(a_index_bound, clk, rst, 1'b1, reply_index <= rhss_pkg::REPLY_LAST_IDX)

endmodule

// ----- verif/rtc_handshake_serial_slave_tb.sv -----
// testbench for the rtc handshake serial slave: bit-banged clock reads against a cycle model
`timescale 1ns / 1ps

module rtc_handshake_serial_slave_tb;

  localparam logic [2:0] GATE_ADDR     = 3'(4 * int'(rhss_pkg::REG_GATE_ID));
  localparam int         SETTLE_CYCLES = 4;
  localparam int         CYCLE_LIMIT   = 300000;
  localparam int         PHASE_ITEMS   = 100;

  // how the time fields of an item are filled
  localparam int TF_RANDOM = 0;
  localparam int TF_ZERO   = 1;
  localparam int TF_ONES   = 2;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rhss_pkg::item_t   drv = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        port_a_value;
  logic [4:0]        port8_value;
  logic              device_clock;
  logic              device_data;
  logic              sending;

  rtc_handshake_serial_slave DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (drv.kind),
    .cpu_clock    (drv.cpu_clock),
    .cpu_data     (drv.cpu_data),
    .now_second   (drv.now_second),
    .now_minute   (drv.now_minute),
    .now_hour     (drv.now_hour),
    .now_day      (drv.now_day),
    .now_weekday  (drv.now_weekday),
    .now_month    (drv.now_month),
    .now_year     (drv.now_year),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .port_a_value (port_a_value),
    .port8_value  (port8_value),
    .device_clock (device_clock),
    .device_data  (device_data),
    .sending      (sending)
  );

  always #5 clk = ~clk;

  // link model state
  logic       m_hclk, m_hdata, m_ready, m_dout, m_send;
  logic [2:0] m_bits_in, m_bits_out, m_idx;
  logic [7:0] m_in_sh, m_out_sh;
  logic       m_pending;
  logic [7:0] m_reply [rhss_pkg::REPLY_LEN];
  logic [3:0] m_gate;

  rhss_pkg::result_t link_results_due[$];

  int  n_fail = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_cmds = 0;
  int  n_early = 0;
  int  n_gates = 0;
  int  cycles = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b1;
  bit  time_wild = 1'b0;
  int  time_fill = TF_RANDOM;

  function automatic void latch_time_reply(rhss_pkg::item_t it);
    logic [6:0] year;
    logic [3:0] wd;
    year = it.now_year;
    if (year >= 7'd100) year = year - 7'd100;
    wd = {1'b0, it.now_weekday} + 4'd15;
    m_reply[0] = {2'b00, it.now_second};
    m_reply[1] = {2'b00, it.now_minute};
    m_reply[2] = {3'b000, it.now_hour};
    m_reply[3] = {3'b000, it.now_day};
    m_reply[4] = {wd, it.now_month};
    m_reply[5] = {1'b0, year};
  endfunction

  function automatic void host_line_change(rhss_pkg::item_t it);
    m_hdata = it.cpu_data;
    if (it.cpu_clock != m_hclk) begin
      m_hclk = it.cpu_clock;
      if (!m_send) begin
        if (m_hclk) begin
          m_ready = 1'b1;
        end else begin
          m_in_sh = {m_in_sh[6:0], m_hdata};
          m_bits_in = m_bits_in + 3'd1;
          if (m_bits_in == 3'd0 && m_in_sh == rhss_pkg::CMD_READ_CLOCK) begin
            latch_time_reply(it);
            m_idx = 3'd0;
            m_pending = 1'b1;
            m_bits_out = 3'd0;
            m_send = 1'b1;
          end
          m_ready = 1'b0;
        end
      end else if (m_hclk) begin
        // byte fetch on the first rising edge of each byte
        if (m_bits_out == 3'd0) begin
          if (m_pending) begin
            m_out_sh = 8'h00;
            m_pending = 1'b0;
          end else if (m_idx < rhss_pkg::REPLY_LEN) begin
            m_out_sh = m_reply[m_idx];
            m_idx = m_idx + 3'd1;
          end else begin
            m_out_sh = 8'h00;
          end
        end
        m_dout = m_out_sh[7];
        m_ready = 1'b0;
      end else begin
        m_bits_out = m_bits_out + 3'd1;
        m_out_sh = {m_out_sh[6:0], 1'b0};
        if (m_bits_out == 3'd0) begin
          if (m_idx < rhss_pkg::REPLY_LEN) m_ready = 1'b1;
          else m_send = 1'b0;
        end else begin
          m_ready = 1'b1;
        end
      end
    end
  endfunction

  function automatic rhss_pkg::result_t link_step(rhss_pkg::item_t it);
    rhss_pkg::result_t r;
    logic [3:0] pa;
    if (it.kind == rhss_pkg::KIND_STATUS) begin
      pa = {m_ready, m_hdata, m_hclk, 1'b0};
      if (m_pending && m_send) begin
        m_ready = 1'b1;
        m_idx = 3'd0;
        m_pending = 1'b0;
      end
    end else begin
      host_line_change(it);
      pa = {m_ready, m_hdata, m_hclk, 1'b0};
    end
    r.port_a_value = pa;
    r.port8_value  = {m_dout && (m_gate < rhss_pkg::GATE_DATA_HIGH), 1'b0,
                      m_dout && (m_gate >= rhss_pkg::GATE_DATA_HIGH), 2'b00};
    r.device_clock = m_ready;
    r.device_data  = m_dout;
    r.sending      = m_send;
    return r;
  endfunction

  function automatic rhss_pkg::item_t make_item(logic k, logic c, logic d);
    rhss_pkg::item_t it;
    it = '0;
    it.kind = k;
    it.cpu_clock = c;
    it.cpu_data = d;
    if (time_fill == TF_ONES) begin
      it.now_second = '1; it.now_minute = '1; it.now_hour = '1; it.now_day = '1;
      it.now_weekday = '1; it.now_month = '1; it.now_year = '1;
    end else if (time_fill == TF_RANDOM) begin
      if (time_wild || $urandom_range(0, 9) == 0) begin
        // full field width, year past the two-digit range
        it.now_second  = 6'($urandom);
        it.now_minute  = 6'($urandom);
        it.now_hour    = 5'($urandom);
        it.now_day     = 5'($urandom);
        it.now_weekday = 3'($urandom);
        it.now_month   = 4'($urandom);
        it.now_year    = 7'($urandom_range(100, 127));
      end else begin
        it.now_second  = 6'($urandom_range(0, 59));
        it.now_minute  = 6'($urandom_range(0, 59));
        it.now_hour    = 5'($urandom_range(0, 23));
        it.now_day     = 5'($urandom_range(1, 31));
        it.now_weekday = 3'($urandom_range(0, 6));
        it.now_month   = 4'($urandom_range(1, 12));
        it.now_year    = 7'($urandom_range(0, 99));
      end
    end
    return it;
  endfunction

  function automatic int pick_gap();
    if (!gaps_on || $urandom_range(0, 99) >= 20) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  task automatic send_item(input rhss_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    drv <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    link_results_due.push_back(link_step(it));
    n_sent++;
  endtask

  task automatic send_line(input logic c, input logic d);
    send_item(make_item(rhss_pkg::KIND_LINE, c, d));
  endtask

  task automatic send_status();
    send_item(make_item(rhss_pkg::KIND_STATUS, 1'($urandom), 1'($urandom)));
  endtask

  // stop offering items and wait for every result, then let the block settle
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gate(input logic [3:0] g);
    wait_drain();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= GATE_ADDR;
    pwdata <= {28'($urandom), g};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    m_gate = g;
    n_gates++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic noise(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_status();
      else send_line(1'($urandom), 1'($urandom));
    end
  endtask

  // one host bit in receive mode: data is taken on the falling edge
  task automatic clock_bit(input logic d);
    if ($urandom_range(0, 9) == 0) send_line(m_hclk, 1'($urandom));
    send_line(1'b1, 1'($urandom));
    send_line(1'b0, d);
  endtask

  task automatic run_clock_read();
    int  guard;
    bit  early;
    early = (n_cmds % 2) == 1;
    time_wild = (n_cmds % 3) == 1;
    if (!m_send) begin
      if (m_hclk) send_line(1'b0, 1'($urandom));
      // pad to a byte boundary so the command lines up
      while (m_bits_in != 3'd0 && !m_send) clock_bit(1'($urandom));
      for (int i = 7; i >= 0; i--) begin
        if (!m_send) clock_bit(rhss_pkg::CMD_READ_CLOCK[i]);
      end
    end
    if (m_pending) begin
      if (early && !m_hclk) begin
        send_line(1'b1, 1'($urandom));
        n_early++;
      end else begin
        send_status();
      end
    end
    guard = 0;
    while (m_send && guard < 400) begin
      case ($urandom_range(0, 19))
        0: send_status();
        1: send_line(m_hclk, 1'($urandom));
        default: send_line(~m_hclk, 1'($urandom));
      endcase
      guard++;
    end
    n_cmds++;
    time_wild = 1'b0;
  endtask

  task automatic test_directed();
    time_fill = TF_ONES;
    send_status();
    time_fill = TF_ZERO;
    send_line(1'b0, 1'b1);
    send_line(1'b1, 1'b1);
    send_line(1'b1, 1'b0);
    send_status();
    send_line(1'b0, 1'b0);
    time_fill = TF_ONES;
    send_line(1'b1, 1'b1);
    send_line(1'b0, 1'b1);
    send_status();
    time_fill = TF_RANDOM;
    noise(8);
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    wait_drain();
    gaps_on = 1'b0;
    hold_left = 60;
    noise(40);
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_phase(input int n);
    int start;
    start = n_sent;
    while (n_sent - start < n) begin
      if ($urandom_range(0, 3) != 0) run_clock_read();
      else noise($urandom_range(3, 15));
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 99) < 20) begin
      out_stall <= 1'b1;
      stall_left = (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3)) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    rhss_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (link_results_due.size() == 0) begin
        $error("result with no item waiting");
        n_fail++;
      end else begin
        want = link_results_due.pop_front();
        if (port_a_value !== want.port_a_value) begin
          $error("port_a_value: expected %0h, got %0h", want.port_a_value, port_a_value);
          n_fail++;
        end
        if (port8_value !== want.port8_value) begin
          $error("port8_value: expected %0h, got %0h", want.port8_value, port8_value);
          n_fail++;
        end
        if (device_clock !== want.device_clock) begin
          $error("device_clock: expected %0h, got %0h", want.device_clock, device_clock);
          n_fail++;
        end
        if (device_data !== want.device_data) begin
          $error("device_data: expected %0h, got %0h", want.device_data, device_data);
          n_fail++;
        end
        if (sending !== want.sending) begin
          $error("sending: expected %0h, got %0h", want.sending, sending);
          n_fail++;
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               link_results_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [3:0] gates [5];
    m_hclk = 1'b0; m_hdata = 1'b0; m_ready = 1'b0; m_dout = 1'b0; m_send = 1'b0;
    m_bits_in = '0; m_bits_out = '0; m_idx = '0;
    m_in_sh = '0; m_out_sh = '0; m_pending = 1'b0; m_gate = '0;
    for (int i = 0; i < rhss_pkg::REPLY_LEN; i++) m_reply[i] = '0;
    gates[0] = 4'd15;
    gates[1] = 4'd3;
    gates[2] = 4'd2;
    gates[3] = 4'($urandom);
    gates[4] = 4'd0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_gate(4'd0);
    test_directed();
    test_backpressure();
    for (int p = 0; p < 5; p++) begin
      write_gate(gates[p]);
      // one phase runs with no idling on either side
      gaps_on = (p != 2);
      test_random_phase(PHASE_ITEMS);
    end
    gaps_on = 1'b1;
    wait_drain();
    repeat (10) @(posedge clk);

    $display("ran %0d items and checked %0d results over %0d gate_id settings",
             n_sent, n_checked, n_gates);
    $display("%0d clock read commands, %0d started by an early host clock", n_cmds, n_early);
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rhss_pkg.sv
rtl/rhss_core.sv
rtl/rtc_handshake_serial_slave.sv
verif/rtc_handshake_serial_slave_tb.sv
